// File: design/pwic_pkg.sv
// Shared types, widths and constants of the PID controller with integral clamp.
`timescale 1ns / 1ps
`default_nettype none

package pwic_pkg;

    // Fixed-point format of signals and gains
    localparam int FRAC_BITS = 16;
    localparam int DT_FRAC   = 16;
    localparam int RATE_FRAC = 8;

    // Field and register widths
    localparam int ERR_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int STEP_T_W   = 16;
    localparam int STEP_R_W   = 24;
    localparam int LIM_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_STEP_TIME      = 3'd3,
        REG_STEP_RATE      = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_OUTPUT_LIMIT   = 3'd6
    } cfg_reg_e_t;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0]   GAIN_P_RST  = 24'd98304;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST  = 24'd3277;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST  = 24'd6554;
    localparam logic [STEP_T_W-1:0] STEP_T_RST  = 16'd655;
    localparam logic [STEP_R_W-1:0] STEP_R_RST  = 24'd25600;
    localparam logic [LIM_W-1:0]    INT_LIM_RST = 23'd32768;
    localparam logic [LIM_W-1:0]    OUT_LIM_RST = 23'd52429;

    // Register set as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [STEP_T_W-1:0] step_time;
        logic [STEP_R_W-1:0] step_rate;
        logic [LIM_W-1:0]    integral_limit;
        logic [LIM_W-1:0]    output_limit;
    } cfg_t;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT,
        MUL_RATE,
        MUL_P,
        MUL_I,
        MUL_DLO,
        MUL_DHI
    } mul_sel_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic     load_in;
        logic     clear;
        mul_sel_t mul_sel;
        logic     upd_integ;
        logic     cap_deriv;
        logic     acc_init;
        logic     acc_add;
        logic     term_lo;
        logic     term_sum;
        logic     acc_term;
        logic     out_load;
        logic     out_zero;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: design/pwic_cfg.sv
// Configuration register file of the PID controller.
`timescale 1ns / 1ps
`default_nettype none

module pwic_cfg (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             wr_en,
    input  wire [pwic_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire [pwic_pkg::CFG_DATA_W-1:0]  wr_data,
    output pwic_pkg::cfg_t                  cfg
);
    import pwic_pkg::*;

    cfg_t cfg_reg;

    // Register writes keep only each register's width; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.step_time      <= STEP_T_RST;
            cfg_reg.step_rate      <= STEP_R_RST;
            cfg_reg.integral_limit <= INT_LIM_RST;
            cfg_reg.output_limit   <= OUT_LIM_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_GAIN_P:         cfg_reg.gain_p         <= wr_data[GAIN_W-1:0];
                REG_GAIN_I:         cfg_reg.gain_i         <= wr_data[GAIN_W-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= wr_data[GAIN_W-1:0];
                REG_STEP_TIME:      cfg_reg.step_time      <= wr_data[STEP_T_W-1:0];
                REG_STEP_RATE:      cfg_reg.step_rate      <= wr_data[STEP_R_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= wr_data[LIM_W-1:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= wr_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/pwic_dp.sv
// Datapath of the PID controller: shared multiplier, state, accumulator, output register.
`timescale 1ns / 1ps
`default_nettype none

module pwic_dp (
    input  wire                          aclk,
    input  pwic_pkg::cfg_t               cfg,
    input  pwic_pkg::dp_cmd_t            cmd,
    input  wire                          aresetn,
    input  wire signed [pwic_pkg::ERR_W-1:0] in_error,
    output logic signed [pwic_pkg::ERR_W-1:0] drive,
    output logic                         saturated
);
    import pwic_pkg::*;

    localparam int MA_W   = ERR_W + 2;         // multiplier operand a, signed
    localparam int MB_W   = GAIN_W + 1;        // multiplier operand b, signed
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = ERR_W + 2;         // integral sum before clamp
    localparam int DIFF_W = ERR_W + 1;
    localparam int DER_W  = ERR_W + 1 + STEP_R_W - RATE_FRAC + 1;
    localparam int MAG_W  = DER_W - 1;
    localparam int LO_W   = 24;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int TERM_W = 62;                // derivative term, capped at 2^61
    localparam int TSUM_W = TERM_W + 4;
    localparam int ACC_W  = 64;

    localparam logic signed [PROD_W-1:0] DT_HALF   = PROD_W'(1) << (DT_FRAC - 1);
    localparam logic signed [PROD_W-1:0] RATE_HALF = PROD_W'(1) << (RATE_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [TSUM_W-1:0]        TERM_CAP  = TSUM_W'(1) << 61;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [ERR_W-1:0]  integ_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     der_neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [TERM_W-1:0]        term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ERR_W-1:0]  drive_reg;
    logic                     sat_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0]        prod_next;

    // Error change against the previous sample
    assign diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    // Operand selection of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_DT: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'(MB_W'(cfg.step_time));
            end
            MUL_RATE: begin
                mul_a = MA_W'(diff);
                mul_b = signed'(MB_W'(cfg.step_rate));
            end
            MUL_P: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'(MB_W'(cfg.gain_p));
            end
            MUL_I: begin
                mul_a = MA_W'(integ_reg);
                mul_b = signed'(MB_W'(cfg.gain_i));
            end
            MUL_DLO: begin
                mul_a = signed'(MA_W'(mag_reg[LO_W-1:0]));
                mul_b = signed'(MB_W'(cfg.gain_d));
            end
            MUL_DHI: begin
                mul_a = signed'(MA_W'(mag_reg[MAG_W-1:LO_W]));
                mul_b = signed'(MB_W'(cfg.gain_d));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Signed 26x25 product, full width
    assign prod_next = mul_a * mul_b;

    // Integral update: round(e*dt), add, clamp to the integral bound
    logic signed [PROD_W-1:0] dt_rnd;
    logic signed [SUM_W-1:0]  delta;
    logic signed [SUM_W-1:0]  isum;
    logic signed [SUM_W-1:0]  ilim;
    logic signed [SUM_W-1:0]  iclamp;

    assign dt_rnd = (prod_reg + DT_HALF) >>> DT_FRAC;
    assign delta  = dt_rnd[SUM_W-1:0];
    assign isum   = SUM_W'(integ_reg) + delta;
    assign ilim   = signed'(SUM_W'(cfg.integral_limit));

    always_comb begin
        priority if (isum > ilim) begin
            iclamp = ilim;
        end else if (isum < -ilim) begin
            iclamp = -ilim;
        end else begin
            iclamp = isum;
        end
    end

    // Derivative: round(diff*rate), kept as sign and magnitude
    logic signed [PROD_W-1:0] der_rnd;
    logic signed [DER_W-1:0]  deriv;
    logic signed [DER_W-1:0]  der_abs;

    assign der_rnd = (prod_reg + RATE_HALF) >>> RATE_FRAC;
    assign deriv   = der_rnd[DER_W-1:0];
    assign der_abs = deriv[DER_W-1] ? -deriv : deriv;

    // Derivative term from two partial products, capped at 2^61
    logic [TSUM_W-1:0] tsum;
    assign tsum = TSUM_W'(term_reg) + (TSUM_W'(prod_reg[HI_W+GAIN_W-1:0]) << LO_W);

    logic signed [ACC_W-1:0] term_s;
    assign term_s = der_neg_reg ? -signed'(ACC_W'(term_reg)) : signed'(ACC_W'(term_reg));

    // Output: round away the fraction bits, clamp to the output bound
    logic signed [ACC_W-1:0] out_rnd;
    logic signed [ACC_W-1:0] olim;
    logic signed [ACC_W-1:0] oclamp;
    logic                    oclip;

    assign out_rnd = (acc_reg + ACC_HALF) >>> FRAC_BITS;
    assign olim    = signed'(ACC_W'(cfg.output_limit));

    always_comb begin
        priority if (out_rnd > olim) begin
            oclamp = olim;
            oclip  = 1'b1;
        end else if (out_rnd < -olim) begin
            oclamp = -olim;
            oclip  = 1'b1;
        end else begin
            oclamp = out_rnd;
            oclip  = 1'b0;
        end
    end

    // Controller state: integral and previous error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else if (cmd.clear) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else begin
            if (cmd.upd_integ) begin
                integ_reg <= iclamp[ERR_W-1:0];
            end
            if (cmd.cap_deriv) begin
                last_err_reg <= err_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            err_reg <= in_error;
        end
        prod_reg <= signed'(prod_next);
        if (cmd.cap_deriv) begin
            der_neg_reg <= deriv[DER_W-1];
            mag_reg     <= der_abs[MAG_W-1:0];
        end
        if (cmd.term_lo) begin
            term_reg <= TERM_W'(prod_reg[2*LO_W-1:0]);
        end else if (cmd.term_sum) begin
            term_reg <= (tsum > TERM_CAP) ? TERM_CAP[TERM_W-1:0] : tsum[TERM_W-1:0];
        end
        if (cmd.acc_init) begin
            acc_reg <= ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end else if (cmd.acc_term) begin
            acc_reg <= acc_reg + term_s;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                drive_reg <= '0;
                sat_reg   <= 1'b0;
            end else begin
                drive_reg <= oclamp[ERR_W-1:0];
                sat_reg   <= oclip;
            end
        end
    end

    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// File: design/pwic_ctrl.sv
// Sequencer of the PID controller: steps the datapath and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module pwic_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    input  wire                 in_clear,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output pwic_pkg::dp_cmd_t   cmd
);
    import pwic_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_MUL_RATE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_DLO,
        ST_MUL_DHI,
        ST_D_SUM,
        ST_D_ACC,
        ST_FINISH,
        ST_CLR_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // Result register may be refilled when empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    // Command decode per step
    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.load_in  = accept;
        cmd.clear    = accept && in_clear;
        unique case (state_reg)
            ST_IDLE: ;
            ST_MUL_DT: cmd.mul_sel = MUL_DT;
            ST_MUL_RATE: begin
                cmd.mul_sel   = MUL_RATE;
                cmd.upd_integ = 1'b1;
            end
            ST_MUL_P: begin
                cmd.mul_sel   = MUL_P;
                cmd.cap_deriv = 1'b1;
            end
            ST_MUL_I: begin
                cmd.mul_sel  = MUL_I;
                cmd.acc_init = 1'b1;
            end
            ST_MUL_DLO: begin
                cmd.mul_sel = MUL_DLO;
                cmd.acc_add = 1'b1;
            end
            ST_MUL_DHI: begin
                cmd.mul_sel = MUL_DHI;
                cmd.term_lo = 1'b1;
            end
            ST_D_SUM:  cmd.term_sum = 1'b1;
            ST_D_ACC:  cmd.acc_term = 1'b1;
            ST_FINISH: cmd.out_load = out_free;
            ST_CLR_OUT: begin
                cmd.out_load = out_free;
                cmd.out_zero = 1'b1;
            end
            default: ;
        endcase
    end

    // State and result-valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= in_clear ? ST_CLR_OUT : ST_MUL_DT;
                    end
                end
                ST_MUL_DT:   state_reg <= ST_MUL_RATE;
                ST_MUL_RATE: state_reg <= ST_MUL_P;
                ST_MUL_P:    state_reg <= ST_MUL_I;
                ST_MUL_I:    state_reg <= ST_MUL_DLO;
                ST_MUL_DLO:  state_reg <= ST_MUL_DHI;
                ST_MUL_DHI:  state_reg <= ST_D_SUM;
                ST_D_SUM:    state_reg <= ST_D_ACC;
                ST_D_ACC:    state_reg <= ST_FINISH;
                ST_FINISH, ST_CLR_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/pid_with_integral_clamp_unit.sv
// Top level of the PID controller with integral clamp and output saturation.
// Compute item: the result is loaded from the finish state once the output register is free,
//   after six passes through the single shared 26x25 multiplier plus add steps; one item at a time.
// Clear item: a zero result is loaded from the clear state once the output register is free.
// A finished result waits in the output register; the next item is taken meanwhile.
// Synchronous active-low reset: registers to their reset values, integral and
//   previous error to zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module pid_with_integral_clamp_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input items
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [23:0]                       s_tdata,   // [23:0] error_sample
    input  wire [0:0]                        s_tuser,   // [0] kind
    // result items
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [23:0]                      m_tdata,   // [23:0] drive
    output logic [0:0]                       m_tuser,   // [0] saturated
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [pwic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [pwic_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pwic_pkg::*;

    cfg_t                    cfg;
    dp_cmd_t                 cmd;
    logic signed [ERR_W-1:0] drive;
    logic                    saturated;

    assign cfg_ready = 1'b1;

    pwic_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pwic_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_clear  (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    pwic_dp u_dp (
        .aclk      (aclk),
        .cfg       (cfg),
        .cmd       (cmd),
        .aresetn   (aresetn),
        .in_error  (signed'(s_tdata[ERR_W-1:0])),
        .drive     (drive),
        .saturated (saturated)
    );

    assign m_tdata    = drive;
    assign m_tuser[0] = saturated;

    // Checks
    logic signed [ERR_W:0] drv_ext;
    logic signed [ERR_W:0] olim_ext;

    assign drv_ext  = (ERR_W + 1)'(drive);
    assign olim_ext = signed'((ERR_W + 1)'(cfg.output_limit));

    // One item at a time: nothing is taken in the cycle after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while a result waits");

    // Offered drive stays within the output bound
    a_drive_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((drv_ext <= olim_ext) && (drv_ext >= -olim_ext)))
        else $error("drive beyond output limit");

    // A saturated result sits exactly on the bound
    a_sat_on_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ((drv_ext == olim_ext) || (drv_ext == -olim_ext)))
        else $error("saturated flag set away from the bound");

endmodule

`default_nettype wire
